### sv/omsat_pkg.sv
// Shared constants and types for the obstacle map summed-area table unit.
// Used by omsat_line_store and obstacle_map_summed_area_table_unit.
package omsat_pkg;

  // Default map size limits
  localparam int unsigned OMSAT_MAX_WIDTH  = 1024;
  localparam int unsigned OMSAT_MAX_HEIGHT = 1024;

  // Fixed field widths
  localparam int unsigned SYM_W     = 8;
  localparam int unsigned DIM_W     = 11;
  localparam int unsigned ROWSUM_W  = 11;
  localparam int unsigned PREFIX_W  = 21;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 11;

  // Row terminator
  localparam logic [SYM_W-1:0] NEWLINE_CODE = 8'd10;

  // Reset values of the registers
  localparam logic [SYM_W-1:0] EMPTY_RST    = 8'd46;
  localparam logic [SYM_W-1:0] OBSTACLE_RST = 8'd111;
  localparam logic [SYM_W-1:0] FILL_RST     = 8'd120;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EMPTY_SYMBOL    = 3'd0,
    REG_OBSTACLE_SYMBOL = 3'd1,
    REG_FILL_SYMBOL     = 3'd2,
    REG_MAP_WIDTH       = 3'd3,
    REG_MAP_HEIGHT      = 3'd4
  } cfg_idx_e;

endpackage

### sv/omsat_line_store.sv
// Line store holding the previous row's prefix sums, one entry per column.
// Synchronous RAM with registered read; a fill count makes unwritten entries read as zero.
// Depends on omsat_pkg.
module omsat_line_store #(
  parameter int unsigned DEPTH = omsat_pkg::OMSAT_MAX_WIDTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           rd_en_i,
  input  logic [$clog2(DEPTH)-1:0]       rd_addr_i,
  output logic [omsat_pkg::PREFIX_W-1:0] rd_data_o,
  input  logic                           wr_en_i,
  input  logic [$clog2(DEPTH)-1:0]       wr_addr_i,
  input  logic [omsat_pkg::PREFIX_W-1:0] wr_data_i
);
  import omsat_pkg::*;

  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

  logic [PREFIX_W-1:0] mem [DEPTH];
  logic [PREFIX_W-1:0] rd_data_q;
  logic                rd_hit_q;
  logic [CNT_W-1:0]    fill_q, fill_d;
  logic [CNT_W-1:0]    wr_next;

  // Columns are always written in ascending order from zero, so the
  // written entries form the range below the fill count.
  assign wr_next = CNT_W'(wr_addr_i) + CNT_W'(1);

  always_comb begin
    fill_d = fill_q;
    if (wr_en_i && (wr_next > fill_q)) begin
      fill_d = wr_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q   <= '0;
      rd_hit_q <= 1'b0;
    end else begin
      fill_q <= fill_d;
      if (rd_en_i) begin
        rd_hit_q <= (CNT_W'(rd_addr_i) < fill_q);
      end
    end
  end

  // RAM array: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_hit_q ? rd_data_q : '0;

endmodule

### sv/obstacle_map_summed_area_table_unit.sv
// Obstacle map summed-area table unit: streaming 2-D prefix sum of obstacle cells.
// Depends on omsat_pkg and omsat_line_store.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / char_code_i) carries one map character
//   per beat: map_width cell characters, then a newline, per row, map_height rows.
//   Output channel (out_valid_o / out_stall_i) returns one beat per input beat with
//   prefix_count_o, is_cell_o, map_ok_o and last_cell_o.
//   Registers are written through cfg_we_i / cfg_idx_i / cfg_wdata_i while idle.
// Throughput: one beat per cycle while the output is not stalled. Pipeline: an
//   accepted beat passes the middle stage, which holds it while the line store read
//   completes, and then the output register.
//   Successive beats never touch the same line store entry while in flight, since
//   a row end always separates two visits to one column.
// Stall: a stalled output beat holds; the middle stage keeps its beat and the input
//   is stalled only when the output beat is stalled and the middle stage is full.
// Reset: counters, running sum and pipeline valids clear, map_ok returns to 1, and
//   the line store reads as zero until written (fill count, no clearing pass).
module obstacle_map_summed_area_table_unit #(
  parameter int unsigned MAX_WIDTH  = omsat_pkg::OMSAT_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = omsat_pkg::OMSAT_MAX_HEIGHT
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration
  input  logic                            cfg_we_i,
  input  logic [omsat_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [omsat_pkg::CFG_DAT_W-1:0] cfg_wdata_i,
  // input channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [omsat_pkg::SYM_W-1:0]     char_code_i,
  // output channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [omsat_pkg::PREFIX_W-1:0]  prefix_count_o,
  output logic                            is_cell_o,
  output logic                            map_ok_o,
  output logic                            last_cell_o
);
  import omsat_pkg::*;

  localparam int unsigned COL_W  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned ROW_W  = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned ADDR_W = $clog2(MAX_WIDTH);
  localparam int unsigned WCMP_W = (COL_W > DIM_W) ? COL_W : DIM_W;
  localparam int unsigned HCMP_W = (ROW_W > DIM_W) ? ROW_W : DIM_W;

  // Configuration registers (dimensions stored already clamped)
  logic [SYM_W-1:0] empty_sym_q, obst_sym_q, fill_sym_q;
  logic [COL_W-1:0] width_q, width_d;
  logic [ROW_W-1:0] height_q, height_d;

  // Map state
  logic [ROWSUM_W-1:0] row_sum_q, row_sum_d;
  logic [COL_W-1:0]    col_q, col_d;
  logic [ROW_W-1:0]    row_q, row_d;
  logic                ok_q, ok_d;

  // Middle stage
  logic                s1_valid_q, s1_valid_d;
  logic                s1_cell_q, s1_last_q, s1_ok_q, s1_rownz_q;
  logic [ROWSUM_W-1:0] s1_base_q;
  logic [ADDR_W-1:0]   s1_addr_q;

  // Output register
  logic                out_valid_q, out_valid_d;
  logic [PREFIX_W-1:0] out_prefix_q;
  logic                out_cell_q, out_ok_q, out_last_q;

  logic                in_acc, s1_adv;
  logic                cell_slot, sym_zero, sym_one, code_ok, last_cell;
  logic [COL_W:0]      col_inc;
  logic [ROW_W:0]      row_inc;
  logic [ROWSUM_W-1:0] row_sum_inc;
  logic [PREFIX_W-1:0] rd_data, s1_prefix;
  logic                rd_en, wr_en;

  // Clamp dimensions when written: zero reads as one, above the limit as the limit
  always_comb begin
    width_d = width_q;
    if (cfg_wdata_i == '0) begin
      width_d = COL_W'(1);
    end else if (WCMP_W'(cfg_wdata_i) > WCMP_W'(MAX_WIDTH)) begin
      width_d = COL_W'(MAX_WIDTH);
    end else begin
      width_d = COL_W'(cfg_wdata_i);
    end
  end

  always_comb begin
    height_d = height_q;
    if (cfg_wdata_i == '0) begin
      height_d = ROW_W'(1);
    end else if (HCMP_W'(cfg_wdata_i) > HCMP_W'(MAX_HEIGHT)) begin
      height_d = ROW_W'(MAX_HEIGHT);
    end else begin
      height_d = ROW_W'(cfg_wdata_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      empty_sym_q <= EMPTY_RST;
      obst_sym_q  <= OBSTACLE_RST;
      fill_sym_q  <= FILL_RST;
      width_q     <= COL_W'(1);
      height_q    <= ROW_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        REG_EMPTY_SYMBOL:    empty_sym_q <= cfg_wdata_i[SYM_W-1:0];
        REG_OBSTACLE_SYMBOL: obst_sym_q  <= cfg_wdata_i[SYM_W-1:0];
        REG_FILL_SYMBOL:     fill_sym_q  <= cfg_wdata_i[SYM_W-1:0];
        REG_MAP_WIDTH:       width_q     <= width_d;
        REG_MAP_HEIGHT:      height_q    <= height_d;
        default: ;
      endcase
    end
  end

  // Handshake: stall only when the middle stage is full and cannot move on
  assign s1_adv     = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  // Classify the incoming beat
  assign cell_slot   = (col_q < width_q);
  assign sym_zero    = (char_code_i == empty_sym_q) || (char_code_i == fill_sym_q);
  assign sym_one     = !sym_zero && (char_code_i == obst_sym_q);
  assign code_ok     = cell_slot ? (sym_zero || sym_one) : (char_code_i == NEWLINE_CODE);
  assign row_sum_inc = row_sum_q + ROWSUM_W'(sym_one);
  assign col_inc     = {1'b0, col_q} + (COL_W + 1)'(1);
  assign row_inc     = {1'b0, row_q} + (ROW_W + 1)'(1);
  assign last_cell   = (col_inc == {1'b0, width_q}) && (row_inc == {1'b0, height_q});

  // Map state update on each accepted beat
  always_comb begin
    row_sum_d = row_sum_q;
    col_d     = col_q;
    row_d     = row_q;
    ok_d      = ok_q;
    if (in_acc) begin
      ok_d = ok_q && code_ok;
      if (cell_slot) begin
        row_sum_d = row_sum_inc;
        col_d     = col_inc[COL_W-1:0];
      end else begin
        row_sum_d = '0;
        col_d     = '0;
        row_d     = (row_inc >= {1'b0, height_q}) ? '0 : row_inc[ROW_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_sum_q <= '0;
      col_q     <= '0;
      row_q     <= '0;
      ok_q      <= 1'b1;
    end else begin
      row_sum_q <= row_sum_d;
      col_q     <= col_d;
      row_q     <= row_d;
      ok_q      <= ok_d;
    end
  end

  // Line store: read at accept, write back as the beat leaves the middle stage
  assign rd_en = in_acc && cell_slot && (row_q != '0);
  assign wr_en = s1_valid_q && s1_cell_q && s1_adv;

  omsat_line_store #(
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (col_q[ADDR_W-1:0]),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (s1_addr_q),
    .wr_data_i (s1_prefix)
  );

  // Middle stage
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_cell_q  <= cell_slot;
      s1_last_q  <= cell_slot && last_cell;
      s1_ok_q    <= ok_d;
      s1_rownz_q <= (row_q != '0);
      s1_base_q  <= cell_slot ? row_sum_inc : '0;
      s1_addr_q  <= col_q[ADDR_W-1:0];
    end
  end

  // Add the previous row's sum at this column
  always_comb begin
    s1_prefix = PREFIX_W'(s1_base_q);
    if (s1_rownz_q) begin
      s1_prefix = PREFIX_W'(s1_base_q) + rd_data;
    end
    if (!s1_cell_q) begin
      s1_prefix = '0;
    end
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_valid_q) begin
      out_prefix_q <= s1_prefix;
      out_cell_q   <= s1_cell_q;
      out_ok_q     <= s1_ok_q;
      out_last_q   <= s1_last_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign prefix_count_o = out_prefix_q;
  assign is_cell_o      = out_cell_q;
  assign map_ok_o       = out_ok_q;
  assign last_cell_o    = out_last_q;

  // Checks
  a_ok_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ok_q |=> !ok_q)
    else $error("map fault flag cleared without reset");

  a_stall_needs_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q))
    else $error("input stalled with a free pipeline slot");

  a_row_end_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !is_cell_o) |-> (prefix_count_o == '0 && !last_cell_o))
    else $error("row end beat carries a count or last flag");

  a_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && cell_slot) |=> (col_q != '0 && col_q <= COL_W'(MAX_WIDTH)))
    else $error("column counter out of range after a cell");

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for obstacle_map_summed_area_table_unit: streams directed
// and random maps under random gaps and stalls and checks every beat against a predictor.
// Depends on omsat_pkg and the unit RTL.
module tb_top;
  import omsat_pkg::*;

  // One output beat as the unit reports it
  typedef struct packed {
    logic [PREFIX_W-1:0] prefix_count;
    logic                is_cell;
    logic                map_ok;
    logic                last_cell;
  } sat_beat_t;

  localparam int unsigned SMALL_MAP_ITEMS = 700;
  localparam int unsigned MAX_PRINTS      = 40;
  localparam int unsigned COL_IDX_W       = $clog2(OMSAT_MAX_WIDTH);

  logic                 clk_i;
  logic                 rst_n     = 1'b0;
  logic                 cfg_we    = 1'b0;
  cfg_idx_e             cfg_idx   = REG_EMPTY_SYMBOL;
  logic [CFG_DAT_W-1:0] cfg_wdata = '0;
  logic                 in_valid  = 1'b0;
  logic [SYM_W-1:0]     char_code = '0;
  logic                 out_stall = 1'b0;
  logic                 in_stall_o;
  logic                 out_valid_o;
  logic [PREFIX_W-1:0]  prefix_count_o;
  logic                 is_cell_o;
  logic                 map_ok_o;
  logic                 last_cell_o;

  // Stimulus and scoreboard state
  logic [SYM_W-1:0] pending_chars[$];
  sat_beat_t        expected_beats[$];
  bit               char_taken     = 1'b0;
  bit               send_gaps_on   = 1'b1;
  bit               recv_stalls_on = 1'b1;
  int unsigned      send_gap       = 0;
  int unsigned      recv_wait      = 0;
  int unsigned      mismatch_count = 0;

  // Predictor copy of registers and map state
  logic [SYM_W-1:0]    empty_sym, obstacle_sym, fill_sym;
  logic [DIM_W-1:0]    width_reg, height_reg;
  logic [ROWSUM_W-1:0] row_sum;
  logic [PREFIX_W-1:0] above_sums[OMSAT_MAX_WIDTH];
  logic [DIM_W-1:0]    cur_col;
  logic [9:0]          cur_row;
  logic                map_good;

  obstacle_map_summed_area_table_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall_o),
    .char_code_i    (char_code),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall),
    .prefix_count_o (prefix_count_o),
    .is_cell_o      (is_cell_o),
    .map_ok_o       (map_ok_o),
    .last_cell_o    (last_cell_o)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // Width and height of 0 act as 1, oversize values saturate
  function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] v, input int unsigned hi);
    if (v == '0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  function automatic int unsigned draw_wait(input bit on);
    return on ? $urandom_range(0, 8) : 0;
  endfunction

  task automatic reset_map_state();
    empty_sym    = EMPTY_RST;
    obstacle_sym = OBSTACLE_RST;
    fill_sym     = FILL_RST;
    width_reg    = DIM_W'(1);
    height_reg   = DIM_W'(1);
    row_sum      = '0;
    cur_col      = '0;
    cur_row      = '0;
    map_good     = 1'b1;
    foreach (above_sums[i]) above_sums[i] = '0;
  endtask

  // Advance the map state by one character and return the beat it yields
  function automatic sat_beat_t predict_sat_beat(input logic [SYM_W-1:0] code);
    int unsigned w, h;
    logic        add;
    sat_beat_t   r;
    w = clamp_dim(width_reg, OMSAT_MAX_WIDTH);
    h = clamp_dim(height_reg, OMSAT_MAX_HEIGHT);
    r = '0;
    if (cur_col < w) begin
      add = 1'b0;
      // empty and fill win over obstacle; anything else spoils the map
      if (code == empty_sym || code == fill_sym) add = 1'b0;
      else if (code == obstacle_sym) add = 1'b1;
      else map_good = 1'b0;
      r.prefix_count = row_sum + add;
      if (cur_row != '0)
        r.prefix_count = r.prefix_count + above_sums[cur_col[COL_IDX_W-1:0]];
      above_sums[cur_col[COL_IDX_W-1:0]] = r.prefix_count;
      row_sum     = row_sum + ROWSUM_W'(add);
      r.is_cell   = 1'b1;
      r.last_cell = (cur_col + 1 == w) && (cur_row + 1 == h);
      cur_col     = cur_col + DIM_W'(1);
    end else begin
      // row-end slot: anything but a newline spoils the map, the row ends anyway
      if (code != NEWLINE_CODE) map_good = 1'b0;
      row_sum = '0;
      cur_col = '0;
      if (int'(cur_row) + 1 >= h) cur_row = '0;
      else cur_row = cur_row + 10'd1;
    end
    r.map_ok = map_good;
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatch_count < MAX_PRINTS) $display("%0t ns: %s", $time, what);
    mismatch_count++;
  endtask

  task automatic write_reg(input cfg_idx_e idx, input int unsigned value);
    logic [CFG_DAT_W-1:0] data;
    data = CFG_DAT_W'(value);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_EMPTY_SYMBOL:    empty_sym    = data[SYM_W-1:0];
      REG_OBSTACLE_SYMBOL: obstacle_sym = data[SYM_W-1:0];
      REG_FILL_SYMBOL:     fill_sym     = data[SYM_W-1:0];
      REG_MAP_WIDTH:       width_reg    = data;
      REG_MAP_HEIGHT:      height_reg   = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic set_symbols(input int unsigned e, input int unsigned o, input int unsigned f);
    write_reg(REG_EMPTY_SYMBOL, e);
    write_reg(REG_OBSTACLE_SYMBOL, o);
    write_reg(REG_FILL_SYMBOL, f);
  endtask

  task automatic set_dims(input int unsigned w, input int unsigned h);
    write_reg(REG_MAP_WIDTH, w);
    write_reg(REG_MAP_HEIGHT, h);
  endtask

  // Every beat comes back, so an empty scoreboard means the unit is idle
  task automatic wait_drained();
    while (pending_chars.size() != 0 || in_valid || expected_beats.size() != 0)
      @(posedge clk_i);
  endtask

  function automatic logic [SYM_W-1:0] pick_cell(input int unsigned obst_pct,
                                                  input int unsigned noise_pct);
    if ($urandom_range(99) < noise_pct) return SYM_W'($urandom_range(255));
    if ($urandom_range(99) < obst_pct) return obstacle_sym;
    return $urandom_range(1) ? empty_sym : fill_sym;
  endfunction

  // Queue rows that continue from the current column, then a partial row of tail cells
  task automatic queue_rows(input int unsigned rows, input int unsigned obst_pct,
                            input int unsigned noise_pct, input int unsigned tail_cells,
                            inout int unsigned count);
    int unsigned w, col;
    w   = clamp_dim(width_reg, OMSAT_MAX_WIDTH);
    col = cur_col;
    repeat (rows) begin
      while (col < w) begin
        pending_chars.push_back(pick_cell(obst_pct, noise_pct));
        col++;
        count++;
      end
      if ($urandom_range(99) < noise_pct) pending_chars.push_back(SYM_W'($urandom_range(255)));
      else pending_chars.push_back(NEWLINE_CODE);
      col = 0;
      count++;
    end
    repeat (tail_cells) begin
      pending_chars.push_back(pick_cell(obst_pct, noise_pct));
      count++;
    end
  endtask

  // Input driver: one beat at a time from the pending queue, with random gaps
  always @(negedge clk_i) begin : drive_chars
    logic hold;
    hold = in_valid && !char_taken;
    if (char_taken) begin
      char_taken = 1'b0;
      send_gap   = draw_wait(send_gaps_on);
    end
    if (!hold) begin
      if (send_gap > 0) send_gap--;
      else if (pending_chars.size() != 0) begin
        char_code <= pending_chars.pop_front();
        hold = 1'b1;
      end
    end
    in_valid <= hold;
  end

  // Accepted input beats feed the predictor
  always @(posedge clk_i) begin
    if (rst_n && in_valid && !in_stall_o) begin
      expected_beats.push_back(predict_sat_beat(char_code));
      char_taken = 1'b1;
    end
  end

  // Output stall: hold off for a random count after each accepted beat
  always @(negedge clk_i) begin
    if (recv_wait > 0) begin
      out_stall <= 1'b1;
      recv_wait--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Output monitor: compare each accepted beat with the oldest prediction
  always @(posedge clk_i) begin : check_beats
    sat_beat_t want;
    if (rst_n && out_valid_o && !out_stall) begin
      recv_wait = draw_wait(recv_stalls_on);
      if (expected_beats.size() == 0) begin
        report_mismatch($sformatf("beat with nothing expected, prefix_count=%0d",
                                  prefix_count_o));
      end else begin
        want = expected_beats.pop_front();
        if (prefix_count_o !== want.prefix_count)
          report_mismatch($sformatf("prefix_count got %0d want %0d",
                                    prefix_count_o, want.prefix_count));
        if (is_cell_o !== want.is_cell)
          report_mismatch($sformatf("is_cell got %b want %b", is_cell_o, want.is_cell));
        if (map_ok_o !== want.map_ok)
          report_mismatch($sformatf("map_ok got %b want %b", map_ok_o, want.map_ok));
        if (last_cell_o !== want.last_cell)
          report_mismatch($sformatf("last_cell got %b want %b", last_cell_o, want.last_cell));
      end
    end
  end

  // Stimulus sequence
  initial begin : run_maps
    int unsigned small_items, wide_items, phase, w, h, rows, tail, pick;
    small_items = 0;
    wide_items  = 0;
    phase       = 0;
    reset_map_state();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_n <= 1'b1;

    // Reset registers: 1x1 maps, one per row
    pending_chars = '{OBSTACLE_RST, NEWLINE_CODE, EMPTY_RST, NEWLINE_CODE,
                      FILL_RST, NEWLINE_CODE};
    wait_drained();

    // Code extremes as symbols, 3x2 map ending on the last cell
    set_symbols(8'h00, 8'hFF, 8'h00);
    set_dims(3, 2);
    pending_chars = '{8'hFF, 8'h00, 8'hFF, NEWLINE_CODE, 8'h00, 8'hFF, 8'hFF, NEWLINE_CODE};
    wait_drained();

    // Obstacle code equal to empty and fill counts as empty
    write_reg(REG_OBSTACLE_SYMBOL, 8'h00);
    set_dims(2, 1);
    pending_chars = '{8'h00, 8'h00, NEWLINE_CODE};
    wait_drained();

    // Newline in a cell slot, unknown code, missing newline; flag stays down
    set_symbols(EMPTY_RST, OBSTACLE_RST, FILL_RST);
    pending_chars = '{NEWLINE_CODE, 8'd200, OBSTACLE_RST, OBSTACLE_RST, EMPTY_RST,
                      NEWLINE_CODE};
    wait_drained();

    // Random maps, with a few size extremes mixed in
    while (small_items < SMALL_MAP_ITEMS) begin
      send_gaps_on   = ($urandom_range(3) != 0);
      recv_stalls_on = ($urandom_range(3) != 0);
      case (phase)
        3: begin
          // oversize width and height saturate: a few cells into a widest row
          set_dims(11'h7FF, 11'h7FF);
          queue_rows(0, 90, 2, 12, wide_items);
        end
        5: begin
          set_dims(OMSAT_MAX_WIDTH, OMSAT_MAX_HEIGHT);
          queue_rows(0, 50, 0, 12, wide_items);
        end
        8: begin
          set_dims(1, OMSAT_MAX_HEIGHT);
          queue_rows(40, 60, 0, 0, wide_items);
        end
        default: begin
          if ($urandom_range(3) != 0)
            set_symbols($urandom_range(255), $urandom_range(255), $urandom_range(255));
          pick = $urandom_range(9);
          w = (pick == 0) ? 0 : (pick == 1) ? $urandom_range(9, 40) : $urandom_range(1, 8);
          pick = $urandom_range(9);
          h = (pick == 0) ? 0 : (pick == 1) ? ($urandom_range(1) ? OMSAT_MAX_HEIGHT : 11'h7FF)
                                            : $urandom_range(1, 6);
          set_dims(w, h);
          w    = clamp_dim(width_reg, OMSAT_MAX_WIDTH);
          rows = $urandom_range(1, (w > 8) ? 3 : 12);
          tail = $urandom_range(1) ? $urandom_range(0, w - 1) : 0;
          queue_rows(rows, $urandom_range(100),
                     ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8), tail, small_items);
        end
      endcase
      wait_drained();
      phase++;
    end

    repeat (6) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
